// ----- hdl/hm71_pkg.sv -----
// Shared types, constants and parity helpers for the Hamming(71,64) codec.
`timescale 1ns / 1ps

package hm71_pkg;

  localparam int unsigned HM71_DATA_W  = 64;
  localparam int unsigned HM71_CHECK_W = 7;
  localparam logic [6:0]  HM71_CW_LEN  = 7'd71;
  localparam logic [2:0]  HM71_LAST_BYTE = 3'd7;

  // Command codes on the input word.
  localparam logic HM71_CMD_ENC = 1'b0;
  localparam logic HM71_CMD_DEC = 1'b1;

  // Item passed from front end to back end through the queue.
  typedef struct packed {
    logic        dec;    // decode when set, encode otherwise
    logic [63:0] data;
    logic [6:0]  chk;    // zero for encode
  } hm71_item_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } hm71_q_stat_t;

  // Codeword position of every data bit, 7 bits per entry, data bit d at [d*7 +: 7].
  // Data bit 63 takes position 3; positions that are powers of two are skipped.
  function automatic logic [447:0] hm71_pos_tab();
    logic [447:0] t;
    int           k;
    t = '0;
    k = 0;
    for (int p = 3; p <= 71; p++) begin
      if ((p & (p - 1)) != 0) begin
        t[(63 - k) * 7 +: 7] = 7'(p);
        k++;
      end
    end
    return t;
  endfunction

  localparam logic [447:0] HM71_POS_TAB = hm71_pos_tab();

  // XOR of the positions of all set data bits.
  function automatic logic [6:0] hm71_data_syn(logic [63:0] data);
    logic [6:0] s;
    s = '0;
    for (int d = 0; d < 64; d++) begin
      if (data[d]) s = s ^ HM71_POS_TAB[d * 7 +: 7];
    end
    return s;
  endfunction

endpackage

// ----- hdl/hm71_front.sv -----
// Front end: accepts input words, assembles bytes into data words, queues work items.
`timescale 1ns / 1ps

module hm71_front import hm71_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  logic         in_cmd,
  input  logic [7:0]   in_data_byte,
  input  logic [63:0]  in_word_data,
  input  logic [6:0]   in_word_check,
  input  hm71_q_stat_t q_stat,
  output logic         q_push,
  output hm71_item_t   q_item
);

  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [55:0] held_r, held_nxt;
  logic        accept;

  assign in_full = q_stat.full;
  assign accept  = in_push && !in_full;

  always_comb begin
    byte_count_nxt = byte_count_r;
    held_nxt       = held_r;
    q_push         = 1'b0;
    q_item.dec     = 1'b0;
    q_item.data    = {held_r, in_data_byte};
    q_item.chk     = '0;
    if (accept) begin
      unique case (in_cmd)
        HM71_CMD_DEC: begin
          q_push      = 1'b1;
          q_item.dec  = 1'b1;
          q_item.data = in_word_data;
          q_item.chk  = in_word_check;
        end
        HM71_CMD_ENC: begin
          if (byte_count_r == HM71_LAST_BYTE) begin
            q_push         = 1'b1;
            byte_count_nxt = '0;
            held_nxt       = '0;
          end else begin
            byte_count_nxt = byte_count_r + 3'd1;
            held_nxt       = {held_r[47:0], in_data_byte};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      held_r       <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

// ----- hdl/hm71_fifo.sv -----
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps

module hm71_fifo import hm71_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  hm71_item_t   push_item,
  input  logic         pop,
  output hm71_item_t   head,
  output hm71_q_stat_t stat
);

  hm71_item_t mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- hdl/hm71_back.sv -----
// Back end: syndrome, single-bit correction and the output register.
`timescale 1ns / 1ps

module hm71_back import hm71_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  hm71_item_t   head,
  input  hm71_q_stat_t q_stat,
  output logic         q_pop,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [63:0]  out_data,
  output logic [6:0]   out_check,
  output logic [6:0]   out_syndrome,
  output logic         out_corrected,
  output logic         out_uncorrectable
);

  logic        valid_r, valid_nxt;
  logic [63:0] data_r, data_nxt;
  logic [6:0]  check_r, check_nxt;
  logic [6:0]  syn_r, syn_nxt;
  logic        corr_r, corr_nxt;
  logic        unc_r, unc_nxt;
  logic [6:0]  syn;
  logic        pow2;
  logic        in_word;
  logic [63:0] flip;

  assign q_pop = !q_stat.empty && (!valid_r || out_pop);

  assign syn     = hm71_data_syn(head.data) ^ head.chk;
  assign pow2    = (syn != 7'd0) && ((syn & (syn - 7'd1)) == 7'd0);
  assign in_word = (syn != 7'd0) && (syn <= HM71_CW_LEN);

  always_comb begin
    for (int d = 0; d < 64; d++) begin
      flip[d] = head.dec && (syn == HM71_POS_TAB[d * 7 +: 7]);
    end
  end

  always_comb begin
    data_nxt  = head.data ^ flip;
    check_nxt = syn;
    syn_nxt   = '0;
    corr_nxt  = 1'b0;
    unc_nxt   = 1'b0;
    if (head.dec) begin
      check_nxt = pow2 ? (head.chk ^ syn) : head.chk;
      syn_nxt   = syn;
      corr_nxt  = in_word;
      unc_nxt   = (syn > HM71_CW_LEN);
    end
    priority if (q_pop)   valid_nxt = 1'b1;
    else if (out_pop)     valid_nxt = 1'b0;
    else                  valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r  <= data_nxt;
      check_r <= check_nxt;
      syn_r   <= syn_nxt;
      corr_r  <= corr_nxt;
      unc_r   <= unc_nxt;
    end
  end

  assign out_empty         = !valid_r;
  assign out_data          = data_r;
  assign out_check         = check_r;
  assign out_syndrome      = syn_r;
  assign out_corrected     = corr_r;
  assign out_uncorrectable = unc_r;

endmodule

// ----- hdl/hamming_71_64_sec_codec_core.sv -----
// Top level of the Hamming(71,64) single-error-correcting encoder/decoder.
// Path: a decode word or the eighth byte of a block is written to the queue at the
//   edge that accepts it and goes through the syndrome tree into the output register.
// Throughput: one word per cycle unless in_full; the correction logic is combinational.
// Reset (synchronous, rst_n low) clears the byte counter, the held bytes,
//   the queue and the output valid flag.
`timescale 1ns / 1ps

module hamming_71_64_sec_codec_core import hm71_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input side
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [63:0] in_word_data,
  input  logic [6:0]  in_word_check,
  // result side
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_data,
  output logic [6:0]  out_check,
  output logic [6:0]  out_syndrome,
  output logic        out_corrected,
  output logic        out_uncorrectable
);

  // Front end packs bytes and classifies words; only a decode word or a
  // completed 8-byte block becomes a queue entry.
  hm71_item_t   q_in_item;
  hm71_item_t   q_head;
  hm71_q_stat_t q_stat;
  logic         q_push;
  logic         q_pop;

  hm71_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cmd        (in_cmd),
    .in_data_byte  (in_data_byte),
    .in_word_data  (in_word_data),
    .in_word_check (in_word_check),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_item        (q_in_item)
  );

  // Two entries decouple input stalls from result stalls.
  hm71_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Back end: encode returns the data with its check bits; decode computes
  // the syndrome and flips the bit it points at, if it lies inside the word.
  hm71_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_data          (out_data),
    .out_check         (out_check),
    .out_syndrome      (out_syndrome),
    .out_corrected     (out_corrected),
    .out_uncorrectable (out_uncorrectable)
  );

endmodule

// ----- hdl/hm71_checker.sv -----
// Port-level checks for the Hamming(71,64) codec, bound to the top level.
`timescale 1ns / 1ps

module hm71_checker import hm71_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [63:0] out_data,
  input logic [6:0]  out_syndrome,
  input logic        out_corrected,
  input logic        out_uncorrectable
);

  // No result survives reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // A waiting result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_corrected && out_uncorrectable))
    else $error("corrected and uncorrectable both set");

  a_unc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_uncorrectable) |-> (out_syndrome > HM71_CW_LEN))
    else $error("uncorrectable with syndrome inside the word");

  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_corrected) |->
      (out_syndrome != 7'd0 && out_syndrome <= HM71_CW_LEN))
    else $error("corrected with syndrome outside the word");

endmodule

bind hamming_71_64_sec_codec_core hm71_checker u_hm71_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_data          (out_data),
  .out_syndrome      (out_syndrome),
  .out_corrected     (out_corrected),
  .out_uncorrectable (out_uncorrectable)
);
